[sv/cdq_pkg.sv]
// cdq_pkg: shared types and constants for the circular deque.
`timescale 1ns / 1ps
package cdq_pkg;

  localparam int unsigned DepthDef = 16;
  localparam int unsigned DataW    = 32;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_REAR  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } cdq_action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } cdq_status_e;

  typedef struct packed {
    cdq_action_e        action;
    logic signed [31:0] push_value;
  } cdq_in_t;

  typedef struct packed {
    cdq_status_e        status;
    logic signed [31:0] pop_value;
    logic               now_empty;
    logic               now_full;
  } cdq_out_t;

  // Per-beat info handed from the index stage to the output stage.
  typedef struct packed {
    cdq_status_e status;
    logic        pop_hit;   // read data of the store is the popped word
    logic        now_empty;
    logic        now_full;
  } cdq_meta_t;

endpackage

[sv/cdq_mem.sv]
// cdq_mem: entry store, one write and one registered read port.
`timescale 1ns / 1ps
module cdq_mem #(
  parameter int unsigned Depth = cdq_pkg::DepthDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [cdq_pkg::DataW-1:0]  wdata_i,
  input  logic                       re_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [cdq_pkg::DataW-1:0]  rdata_o
);
  import cdq_pkg::*;

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/cdq_ctrl.sv]
// cdq_ctrl: front/rear indices, empty flag, store access and stage-1 register.
`timescale 1ns / 1ps
module cdq_ctrl #(
  parameter int unsigned Depth = cdq_pkg::DepthDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  cdq_pkg::cdq_in_t           in_beat_i,
  output logic                       mem_we_o,
  output logic [AddrW-1:0]           mem_waddr_o,
  output logic [cdq_pkg::DataW-1:0]  mem_wdata_o,
  output logic                       mem_re_o,
  output logic [AddrW-1:0]           mem_raddr_o,
  output logic                       s1_valid_o,
  input  logic                       s1_ready_i,
  output cdq_pkg::cdq_meta_t         s1_meta_o
);
  import cdq_pkg::*;

  localparam logic [AddrW-1:0] LastIdx = AddrW'(Depth - 1);

  function automatic logic [AddrW-1:0] idx_next(input logic [AddrW-1:0] i);
    idx_next = (i == LastIdx) ? '0 : i + AddrW'(1);
  endfunction

  function automatic logic [AddrW-1:0] idx_prev(input logic [AddrW-1:0] i);
    idx_prev = (i == '0) ? LastIdx : i - AddrW'(1);
  endfunction

  logic [AddrW-1:0] front_q, front_d, rear_q, rear_d;
  logic             empty_q, empty_d;
  logic             full_now;
  logic             accept;
  logic             s1_valid_q, s1_valid_d;
  cdq_meta_t        s1_q, s1_d;

  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full_now   = !empty_q && (idx_next(rear_q) == front_q);

  always_comb begin
    front_d     = front_q;
    rear_d      = rear_q;
    empty_d     = empty_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = in_beat_i.push_value;
    mem_re_o    = 1'b0;
    mem_raddr_o = front_q;
    s1_d        = s1_q;
    s1_d.status = ST_DONE;
    s1_d.pop_hit = 1'b0;

    case (in_beat_i.action)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (full_now) begin
          s1_d.status = ST_FULL;
        end else if (empty_q) begin
          // first entry always lands at slot zero
          front_d     = '0;
          rear_d      = '0;
          empty_d     = 1'b0;
          mem_we_o    = accept;
          mem_waddr_o = '0;
        end else if (in_beat_i.action == ACT_PUSH_FRONT) begin
          front_d     = idx_prev(front_q);
          mem_we_o    = accept;
          mem_waddr_o = idx_prev(front_q);
        end else begin
          rear_d      = idx_next(rear_q);
          mem_we_o    = accept;
          mem_waddr_o = idx_next(rear_q);
        end
      end
      ACT_POP_FRONT, ACT_POP_REAR: begin
        if (empty_q) begin
          s1_d.status = ST_EMPTY;
        end else begin
          mem_re_o     = accept;
          mem_raddr_o  = (in_beat_i.action == ACT_POP_FRONT) ? front_q : rear_q;
          s1_d.pop_hit = 1'b1;
          if (front_q == rear_q) begin
            // last entry leaves, indices go home
            front_d = '0;
            rear_d  = '0;
            empty_d = 1'b1;
          end else if (in_beat_i.action == ACT_POP_FRONT) begin
            front_d = idx_next(front_q);
          end else begin
            rear_d  = idx_prev(rear_q);
          end
        end
      end
      default: begin
        s1_d.status = ST_DONE;
      end
    endcase

    s1_d.now_empty = empty_d;
    s1_d.now_full  = !empty_d && (idx_next(rear_d) == front_d);

    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_ready_i) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q    <= '0;
      rear_q     <= '0;
      empty_q    <= 1'b1;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        front_q <= front_d;
        rear_q  <= rear_d;
        empty_q <= empty_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_meta_o  = s1_q;

  a_empty_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (front_q == '0) && (rear_q == '0))
    else $error("empty deque with indices off slot zero");

  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o))
    else $error("store read and written by one beat");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_ready_i) |=> (s1_valid_q && $stable(s1_q)))
    else $error("stage-1 beat changed while stalled");

  a_pop_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s1_d.status == ST_DONE && s1_d.pop_hit) |-> mem_re_o)
    else $error("pop without store read");

endmodule

[sv/circular_deque.sv]
// circular_deque: top level, deque with a circular entry store.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in      | input     | in_valid_i/in_ready_o   | in_beat_i   (cdq_in_t)
//  out     | output    | out_valid_o/out_ready_i | out_beat_o  (cdq_out_t)
//
// One beat per cycle sustained while out_ready_i keeps taking results; out_valid_o
// rises once the beat has passed the stage-1 register (index update and store
// access) and then the output register.
// The store has a single registered read port: the popped word arrives in the
// cycle after the accept and stays in the read register until the output register captures it.
// Reset leaves the deque empty with both indices at zero; the store is not
// cleared, since only occupied entries are ever read.
// A stalled output holds its beat; the stage in front of it holds one more,
// and the input stalls only once both are full.
`timescale 1ns / 1ps
module circular_deque #(
  parameter int unsigned Depth = cdq_pkg::DepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cdq_pkg::cdq_in_t  in_beat_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cdq_pkg::cdq_out_t out_beat_o
);
  import cdq_pkg::*;

  localparam int unsigned AddrW = $clog2(Depth);

  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [DataW-1:0] mem_wdata, mem_rdata;

  logic      s1_valid, s1_ready;
  cdq_meta_t s1_meta;

  logic      out_valid_q, out_valid_d;
  cdq_out_t  out_q, out_d;

  cdq_ctrl #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .s1_valid_o  (s1_valid),
    .s1_ready_i  (s1_ready),
    .s1_meta_o   (s1_meta)
  );

  cdq_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register drains stage 1 whenever it is free or being emptied.
  assign s1_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_d.status    = s1_meta.status;
    out_d.pop_value = s1_meta.pop_hit ? mem_rdata : '0;
    out_d.now_empty = s1_meta.now_empty;
    out_d.now_full  = s1_meta.now_full;
    if (s1_valid && s1_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid && s1_ready) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.now_empty && out_q.now_full))
    else $error("result reports empty and full together");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_DONE) |-> (out_q.pop_value == '0))
    else $error("rejected beat carries a popped word");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && !s1_ready) |-> (out_valid_q && !out_ready_i))
    else $error("stage 1 stalled behind a free output");

endmodule

[tb/circular_deque_tb.sv]
// circular_deque_tb: self-checking testbench for the circular deque.
`timescale 1ns / 1ps
module circular_deque_tb;
  import cdq_pkg::*;

  localparam int unsigned Depth    = DepthDef;
  localparam int unsigned HoldLen  = 50;   // long output hold-off, in cycles
  localparam int unsigned PhaseLen = 576;  // random beats per idling phase

  // Directed stimulus row; a row with has_res set carries its own expected
  // result, all other rows are checked against the shadow deque.
  typedef struct {
    cdq_action_e act;
    logic [31:0] val;
    bit          has_res;
    cdq_out_t    res;
  } stim_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     out_ready_i = 1'b0;
  cdq_in_t  in_beat_i   = '0;
  logic     in_ready_o;
  logic     out_valid_o;
  cdq_out_t out_beat_o;

  // Shadow deque: entries, front/rear positions and fill level.
  logic signed [31:0] shadow_mem [Depth];
  int                 head_pos  = 0;
  int                 tail_pos  = 0;
  int                 fill_lvl  = 0;
  bit                 fill_mode = 1'b1;  // random part leans toward pushes

  cdq_out_t  pending_res [$];
  stim_row_t stim_tab [$];

  int unsigned snd_idle = 19;
  int unsigned rcv_idle = 47;
  bit          hold_go  = 1'b0;
  int unsigned hold_left = 0;

  int unsigned err_cnt     = 0;
  int unsigned chk_cnt     = 0;
  int unsigned in_stall    = 0;
  int unsigned act_cnt [4] = '{default: 0};
  int unsigned st_cnt  [4] = '{default: 0};

  circular_deque #(.Depth(Depth)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_beat_o (out_beat_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one accepted beat to the shadow deque and return its result.
  function automatic cdq_out_t deque_apply(cdq_in_t b);
    cdq_out_t r;
    int       pos;
    r        = '0;
    r.status = ST_DONE;
    case (b.action)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (fill_lvl == Depth) begin
          r.status = ST_FULL;
        end else if (fill_lvl == 0) begin
          // first entry always lands at slot 0, whichever end was named
          head_pos      = 0;
          tail_pos      = 0;
          shadow_mem[0] = b.push_value;
          fill_lvl      = 1;
        end else if (b.action == ACT_PUSH_FRONT) begin
          head_pos             = (head_pos == 0) ? Depth - 1 : head_pos - 1;
          shadow_mem[head_pos] = b.push_value;
          fill_lvl++;
        end else begin
          tail_pos             = (tail_pos == Depth - 1) ? 0 : tail_pos + 1;
          shadow_mem[tail_pos] = b.push_value;
          fill_lvl++;
        end
      end
      default: begin
        if (fill_lvl == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos         = (b.action == ACT_POP_FRONT) ? head_pos : tail_pos;
          r.pop_value = shadow_mem[pos];
          if (fill_lvl == 1) begin
            // last entry gone: both ends snap back to slot 0
            head_pos = 0;
            tail_pos = 0;
          end else if (b.action == ACT_POP_FRONT) begin
            head_pos = (head_pos == Depth - 1) ? 0 : head_pos + 1;
          end else begin
            tail_pos = (tail_pos == 0) ? Depth - 1 : tail_pos - 1;
          end
          fill_lvl--;
        end
      end
    endcase
    r.now_empty = (fill_lvl == 0);
    r.now_full  = (fill_lvl == Depth);
    return r;
  endfunction

  function automatic stim_row_t mk_row(cdq_action_e act, logic [31:0] val, bit has_res,
                                       cdq_status_e st, logic [31:0] pv, logic em,
                                       logic fu);
    stim_row_t row;
    row.act               = act;
    row.val               = val;
    row.has_res           = has_res;
    row.res.status        = st;
    row.res.pop_value     = pv;
    row.res.now_empty     = em;
    row.res.now_full      = fu;
    return row;
  endfunction

  // Random beat: mostly runs of pushes then runs of pops so the deque sweeps
  // between empty and full and wraps often; some uniform noise on top.
  function automatic cdq_in_t gen_beat();
    cdq_in_t b;
    int      r;
    bit      push;
    if ((fill_lvl == Depth && fill_mode) || (fill_lvl == 0 && !fill_mode)) begin
      if ($urandom_range(0, 99) < 30) fill_mode = ~fill_mode;
    end else if ($urandom_range(0, 99) < 3) begin
      fill_mode = ~fill_mode;
    end
    r = $urandom_range(0, 99);
    if (r < 15) push = 1'($urandom_range(0, 1));
    else        push = fill_mode ? (r < 80) : (r < 35);
    if (push) b.action = $urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
    else      b.action = $urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT;
    case ($urandom_range(0, 11))
      0:       b.push_value = 32'sh8000_0000;
      1:       b.push_value = 32'sh7fff_ffff;
      2:       b.push_value = '0;
      3:       b.push_value = '1;
      default: b.push_value = $urandom;
    endcase
    return b;
  endfunction

  // Offer one beat; the expectation is queued at the negedge before the
  // accepting edge, returns right after that edge.
  task automatic send_beat(cdq_in_t b, bit has_res, cdq_out_t res);
    cdq_out_t r;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    r = deque_apply(b);
    pending_res.push_back(has_res ? res : r);
    act_cnt[b.action]++;
    @(posedge clk_i);
  endtask

  // Sender stops and waits until every queued result is back.
  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_res.size() != 0);
  endtask

  // Receiver: random ready, or a long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = HoldLen;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // Output check; inputs settle at the posedge, so the negedge sees what
  // the next edge will accept.
  always @(negedge clk_i) begin
    cdq_out_t e;
    if (rst_ni) begin
      if (in_valid_i && !in_ready_o) in_stall++;
      if (out_valid_o && out_ready_i) begin
        chk_cnt++;
        st_cnt[out_beat_o.status]++;
        if (pending_res.size() == 0) begin
          $error("unexpected result beat: status %0d pop_value %h",
                 out_beat_o.status, out_beat_o.pop_value);
          err_cnt++;
        end else begin
          e = pending_res.pop_front();
          if (out_beat_o.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_beat_o.status);
            err_cnt++;
          end
          if (out_beat_o.pop_value !== e.pop_value) begin
            $error("pop_value: expected %h, got %h", e.pop_value, out_beat_o.pop_value);
            err_cnt++;
          end
          if (out_beat_o.now_empty !== e.now_empty) begin
            $error("now_empty: expected %0b, got %0b", e.now_empty, out_beat_o.now_empty);
            err_cnt++;
          end
          if (out_beat_o.now_full !== e.now_full) begin
            $error("now_full: expected %0b, got %0b", e.now_full, out_beat_o.now_full);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    cdq_in_t b;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pops on empty, push/pop of the extreme words down to empty,
    // a full fill from both ends that wraps the front, then pushes on full.
    stim_tab.push_back(mk_row(ACT_POP_FRONT, 32'h0, 1'b1, ST_EMPTY, 32'h0, 1'b1, 1'b0));
    stim_tab.push_back(mk_row(ACT_POP_REAR, '1, 1'b1, ST_EMPTY, 32'h0, 1'b1, 1'b0));
    stim_tab.push_back(mk_row(ACT_PUSH_FRONT, 32'h8000_0000, 1'b0, ST_DONE, 32'h0,
                              1'b0, 1'b0));
    stim_tab.push_back(mk_row(ACT_POP_REAR, 32'h0, 1'b1, ST_DONE, 32'h8000_0000,
                              1'b1, 1'b0));
    stim_tab.push_back(mk_row(ACT_PUSH_REAR, 32'h7fff_ffff, 1'b0, ST_DONE, 32'h0,
                              1'b0, 1'b0));
    stim_tab.push_back(mk_row(ACT_POP_FRONT, 32'h0, 1'b1, ST_DONE, 32'h7fff_ffff,
                              1'b1, 1'b0));
    for (int k = 0; k < Depth; k++) begin
      stim_tab.push_back(mk_row(k[0] ? ACT_PUSH_REAR : ACT_PUSH_FRONT,
                                (k[1] ? 32'ha5a5_0000 : 32'h5a5a_0000) | 32'(k),
                                1'b0, ST_DONE, 32'h0, 1'b0, 1'b0));
    end
    stim_tab.push_back(mk_row(ACT_PUSH_FRONT, '1, 1'b1, ST_FULL, 32'h0, 1'b0, 1'b1));
    stim_tab.push_back(mk_row(ACT_PUSH_REAR, 32'h0, 1'b1, ST_FULL, 32'h0, 1'b0, 1'b1));

    foreach (stim_tab[i]) begin
      b.action     = stim_tab[i].act;
      b.push_value = stim_tab[i].val;
      send_beat(b, stim_tab[i].has_res, stim_tab[i].res);
    end
    pause_until_drained();

    // Random part in three idling phases; the last one has no idling but
    // opens with a long output hold-off so the input backs up.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin snd_idle = 19; rcv_idle = 47; end
        1:       begin snd_idle = 47; rcv_idle = 19; end
        default: begin snd_idle = 0;  rcv_idle = 0;  hold_go = 1'b1; end
      endcase
      for (int n = 0; n < PhaseLen; n++) begin
        send_beat(gen_beat(), 1'b0, '0);
      end
      pause_until_drained();
    end

    repeat (8) @(posedge clk_i);
    $display("Checked %0d results: push front %0d, push rear %0d, pop front %0d, pop rear %0d",
             chk_cnt, act_cnt[ACT_PUSH_FRONT], act_cnt[ACT_PUSH_REAR],
             act_cnt[ACT_POP_FRONT], act_cnt[ACT_POP_REAR]);
    $display("Rejected on full %0d, on empty %0d; input held off for %0d cycles",
             st_cnt[ST_FULL], st_cnt[ST_EMPTY], in_stall);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
